/* rtl/erm_pkg.sv */
// Package for the Euler XYZ rotation matrix block.
// Holds widths, CORDIC constants, the arctangent table and fixed-point helpers.
package erm_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int TAB_LEN = 32;
    localparam int N_IT = (CORDIC_ITERATIONS < TAB_LEN) ? CORDIC_ITERATIONS : TAB_LEN;
    localparam int ANGLE_W = 16;
    localparam int VAL_W = 16;
    // Q.30 working words: 34 bits covers +/- pi and CORDIC growth
    localparam int W = 34;
    localparam int ONE_Q14 = 16384;

    localparam logic signed [W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [W-1:0] INV_GAIN_Q30 = 34'sd652032874;

    typedef logic signed [W-1:0] word_t;

    // per-angle CORDIC lane state
    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        logic  neg;
    } lane_t;

    // one cell carries all three angles
    typedef struct packed {
        logic  vld;
        lane_t ax;
        lane_t ay;
        lane_t az;
    } cell_t;

    function automatic word_t atan_tab(input int i);
        word_t r;
        case (i)
            0: r = 34'sh3243F6A8;  1: r = 34'sh1DAC6705;  2: r = 34'sh0FADBAFC;
            3: r = 34'sh07F56EA6;  4: r = 34'sh03FEAB76;  5: r = 34'sh01FFD55B;
            6: r = 34'sh00FFFAAA;  7: r = 34'sh007FFF55;  8: r = 34'sh003FFFEA;
            9: r = 34'sh001FFFFD;  10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
            12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF; 14: r = 34'sh0000FFFF;
            15: r = 34'sh00007FFF; 16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
            18: r = 34'sh00000FFF; 19: r = 34'sh000007FF; 20: r = 34'sh000003FF;
            21: r = 34'sh000001FF; 22: r = 34'sh000000FF; 23: r = 34'sh0000007F;
            24: r = 34'sh0000003F; 25: r = 34'sh0000001F; 26: r = 34'sh0000000F;
            27: r = 34'sh00000008; 28: r = 34'sh00000004; 29: r = 34'sh00000002;
            30: r = 34'sh00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q.30 product, rounded half up
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [2*W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return word_t'(p >>> 30);
    endfunction

    // Q.30 to saturated Q1.14
    function automatic logic signed [VAL_W-1:0] to_q14(input word_t v);
        word_t r;
        r = (v + (34'sd1 <<< 15)) >>> 16;
        if (r > word_t'(ONE_Q14))
            r = word_t'(ONE_Q14);
        else if (r < -word_t'(ONE_Q14))
            r = -word_t'(ONE_Q14);
        return r[VAL_W-1:0];
    endfunction

endpackage

/* rtl/erm_cell.sv */
// One CORDIC micro-rotation cell, applied to all three angle lanes.
// Depends on erm_pkg; the shift step is tied to a constant by the top level.
module erm_cell
    import erm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] step,
    input  cell_t      din,
    output cell_t      dout
);

    logic  vld_reg;
    lane_t ax_reg;
    lane_t ay_reg;
    lane_t az_reg;
    cell_t dout_next;

    function automatic lane_t rot(input lane_t l, input logic [4:0] s);
        lane_t o;
        o = l;
        if (!l.z[W-1])
        begin
            o.x = l.x - (l.y >>> s);
            o.y = l.y + (l.x >>> s);
            o.z = l.z - atan_tab(int'(s));
        end
        else
        begin
            o.x = l.x + (l.y >>> s);
            o.y = l.y - (l.x >>> s);
            o.z = l.z + atan_tab(int'(s));
        end
        return o;
    endfunction

    // rotate each lane by one step
    always_comb
    begin
        dout_next.vld = din.vld;
        dout_next.ax = rot(din.ax, step);
        dout_next.ay = rot(din.ay, step);
        dout_next.az = rot(din.az, step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= dout_next.vld;
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= dout_next.ax;
        ay_reg <= dout_next.ay;
        az_reg <= dout_next.az;
    end

    assign dout = '{vld: vld_reg, ax: ax_reg, ay: ay_reg, az: az_reg};

endmodule

/* rtl/erm_matrix.sv */
// Sign and product stages and element sequencer: forms the 3x3 entries and emits 16 elements.
// Depends on erm_pkg.
module erm_matrix
    import erm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_t             din,
    output logic              strobe,
    output logic [1:0]        row_index,
    output logic [1:0]        col_index,
    output logic signed [VAL_W-1:0] element_value,
    output logic              last_element
);

    // stage 1: signs applied
    word_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic  v1_reg;
    // stage 2: two-factor products
    word_t sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg, cxcz_reg;
    word_t sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    word_t sy2_reg, sz2_reg, cz2_reg;
    logic  v2_reg;
    // stage 3: entries held for output
    logic signed [VAL_W-1:0] m_reg [9];
    logic  v3_reg;
    logic [3:0] k_reg;
    logic  act_reg;
    logic  strobe_reg;
    logic [3:0] ko_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [3:0] m_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            act_reg <= 1'b0;
            k_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= din.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            strobe_reg <= act_reg;
            if (v3_reg)
            begin
                act_reg <= 1'b1;
                k_reg <= '0;
            end
            else if (act_reg)
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg == 4'd15)
                    act_reg <= 1'b0;
            end
        end
    end

    // entry index: row * 3 + column
    assign m_idx = ({2'b00, k_reg[3:2]} * 4'd3) + {2'b00, k_reg[1:0]};

    // datapath
    always_ff @(posedge clk)
    begin
        sx_reg <= din.ax.neg ? -din.ax.y : din.ax.y;
        cx_reg <= din.ax.neg ? -din.ax.x : din.ax.x;
        sy_reg <= din.ay.neg ? -din.ay.y : din.ay.y;
        cy_reg <= din.ay.neg ? -din.ay.x : din.ay.x;
        sz_reg <= din.az.neg ? -din.az.y : din.az.y;
        cz_reg <= din.az.neg ? -din.az.x : din.az.x;

        sxsy_reg <= qmul(sx_reg, sy_reg);
        cxsy_reg <= qmul(cx_reg, sy_reg);
        cycz_reg <= qmul(cy_reg, cz_reg);
        cysz_reg <= qmul(cy_reg, sz_reg);
        cxsz_reg <= qmul(cx_reg, sz_reg);
        cxcz_reg <= qmul(cx_reg, cz_reg);
        sxcy_reg <= qmul(sx_reg, cy_reg);
        sxsz_reg <= qmul(sx_reg, sz_reg);
        sxcz_reg <= qmul(sx_reg, cz_reg);
        cxcy_reg <= qmul(cx_reg, cy_reg);
        sy2_reg <= sy_reg;
        sz2_reg <= sz_reg;
        cz2_reg <= cz_reg;

        if (v2_reg)
        begin
            m_reg[0] <= to_q14(cycz_reg);
            m_reg[1] <= to_q14(-cysz_reg);
            m_reg[2] <= to_q14(sy2_reg);
            m_reg[3] <= to_q14(qmul(sxsy_reg, cz2_reg) + cxsz_reg);
            m_reg[4] <= to_q14(cxcz_reg - qmul(sxsy_reg, sz2_reg));
            m_reg[5] <= to_q14(-sxcy_reg);
            m_reg[6] <= to_q14(sxsz_reg - qmul(cxsy_reg, cz2_reg));
            m_reg[7] <= to_q14(qmul(cxsy_reg, sz2_reg) + sxcz_reg);
            m_reg[8] <= to_q14(cxcy_reg);
        end

        ko_reg <= k_reg;
        if (k_reg[1:0] == 2'd3 || k_reg[3:2] == 2'd3)
            val_reg <= (k_reg == 4'd15) ? VAL_W'(ONE_Q14) : '0;
        else
            val_reg <= m_reg[m_idx];
    end

    assign strobe = strobe_reg;
    assign row_index = ko_reg[3:2];
    assign col_index = ko_reg[1:0];
    assign element_value = val_reg;
    assign last_element = strobe_reg && (ko_reg == 4'd15);

endmodule

/* rtl/euler_rotation_matrix.sv */
// Top level of the Euler XYZ rotation matrix block.
// Depends on erm_pkg, erm_cell and erm_matrix.
//
// Usage: drive angle_x/y/z (signed Q3.13 radians) and raise start; the
// request is taken at a clock edge with start high and busy low.
// The block returns the 16 elements of Rx*Ry*Rz, row-major, one per cycle,
// each marked by strobe for a single cycle; last_element flags element 15.
// A request passes 16 CORDIC cells, a sign stage, two product stages, the
// sequencer load and the output register before strobe marks its first
// element; the other elements follow in row-major order up to element 15.
// Requests are paced to the output sequencer, which streams one element per
// cycle; busy is high while a pacing counter runs down after each accept,
// so a new request can be taken while the chain works on older angles.
// Reset clears all valid flags and the sequencer; requests in flight are
// dropped and no elements are invented. The receiver cannot stall: results
// must be taken as they come.
module euler_rotation_matrix
    import erm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ANGLE_W-1:0] angle_x,
    input  logic signed [ANGLE_W-1:0] angle_y,
    input  logic signed [ANGLE_W-1:0] angle_z,
    output logic                     strobe,
    output logic [1:0]               row_index,
    output logic [1:0]               col_index,
    output logic signed [VAL_W-1:0]  element_value,
    output logic                     last_element
);

    cell_t chain [N_IT+1];
    logic [3:0] gap_reg;

    // pace requests: count down after each accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else if (start && !busy)
            gap_reg <= 4'd15;
        else if (gap_reg != 4'd0)
            gap_reg <= gap_reg - 4'd1;
    end

    assign busy = (gap_reg != 4'd0);

    // half-turn reduction of one angle
    function automatic lane_t reduce(input logic signed [ANGLE_W-1:0] a);
        lane_t l;
        word_t t;
        t = word_t'(a) <<< 17;
        l.neg = 1'b0;
        if (t > HALF_PI_Q30)
        begin
            t = t - PI_Q30;
            l.neg = 1'b1;
        end
        else if (t < -HALF_PI_Q30)
        begin
            t = t + PI_Q30;
            l.neg = 1'b1;
        end
        l.x = INV_GAIN_Q30;
        l.y = '0;
        l.z = t;
        return l;
    endfunction

    always_comb
    begin
        chain[0].vld = start && !busy;
        chain[0].ax = reduce(angle_x);
        chain[0].ay = reduce(angle_y);
        chain[0].az = reduce(angle_z);
    end

    // CORDIC chain
    for (genvar i = 0; i < N_IT; i++)
    begin : g_cell
        erm_cell u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .step (5'(i)),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    erm_matrix u_matrix
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .din          (chain[N_IT]),
        .strobe       (strobe),
        .row_index    (row_index),
        .col_index    (col_index),
        .element_value(element_value),
        .last_element (last_element)
    );

endmodule

/* tb/sv/tb_euler_rotation_matrix.sv */
`timescale 1ns / 1ps
// Self-checking testbench for euler_rotation_matrix (Rx*Ry*Rz, Q1.14 elements).
// Depends on erm_pkg and the RTL of the block; predicts each matrix in the bench.
module tb_euler_rotation_matrix
    import erm_pkg::*;
;

    localparam longint PI_VAL   = 64'sd3373259426;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint INV_GAIN = 64'sd652032874;
    localparam int     ITERS    = N_IT;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [15:0] value;
        logic              last;
    } element_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] angle_x = '0;
    logic signed [15:0] angle_y = '0;
    logic signed [15:0] angle_z = '0;
    logic strobe;
    logic [1:0] row_index;
    logic [1:0] col_index;
    logic signed [15:0] element_value;
    logic last_element;

    element_t expected_elements[$];
    int error_count = 0;
    int idle_pct = 0;
    longint cycle_count = 0;

    euler_rotation_matrix uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .strobe(strobe), .row_index(row_index), .col_index(col_index),
        .element_value(element_value), .last_element(last_element)
    );

    always #1 clk = ~clk;

    // floor shift of a signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // CORDIC sine and cosine in Q.30, with half-turn reduction
    task automatic sin_cos(input logic signed [15:0] ang, output longint sn,
                           output longint cs);
        longint t, x, y, nx, ny;
        bit flip;
        t = longint'(ang) * 131072;
        flip = 1'b0;
        if (t > HALF_PI)
        begin
            t -= PI_VAL;
            flip = 1'b1;
        end
        else if (t < -HALF_PI)
        begin
            t += PI_VAL;
            flip = 1'b1;
        end
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            if (t >= 0)
            begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                t -= longint'(atan_tab(i));
            end
            else
            begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                t += longint'(atan_tab(i));
            end
            x = nx;
            y = ny;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic logic signed [15:0] sat_q14(input longint v);
        longint r;
        r = floor_shr(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    // queue the sixteen matrix elements for one request
    task automatic predict_matrix(input logic signed [15:0] ax,
                                  input logic signed [15:0] ay,
                                  input logic signed [15:0] az);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        longint m[9];
        element_t e;
        sin_cos(ax, sx, cx);
        sin_cos(ay, sy, cy);
        sin_cos(az, sz, cz);
        sxsy = fx_mul(sx, sy);
        cxsy = fx_mul(cx, sy);
        m[0] = fx_mul(cy, cz);
        m[1] = -fx_mul(cy, sz);
        m[2] = sy;
        m[3] = fx_mul(sxsy, cz) + fx_mul(cx, sz);
        m[4] = fx_mul(cx, cz) - fx_mul(sxsy, sz);
        m[5] = -fx_mul(sx, cy);
        m[6] = fx_mul(sx, sz) - fx_mul(cxsy, cz);
        m[7] = fx_mul(cxsy, sz) + fx_mul(sx, cz);
        m[8] = fx_mul(cx, cy);
        for (int k = 0; k < 16; k++)
        begin
            e.row = 2'(k / 4);
            e.col = 2'(k % 4);
            if (k / 4 < 3 && k % 4 < 3)
                e.value = sat_q14(m[(k / 4) * 3 + k % 4]);
            else if (k == 15)
                e.value = 16'sd16384;
            else
                e.value = '0;
            e.last = (k == 15);
            expected_elements.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    // send one request, with random idle cycles before it; start stays high
    // after the accept until the next idle cycle or the drain
    task automatic send_request(input logic signed [15:0] ax,
                                input logic signed [15:0] ay,
                                input logic signed [15:0] az);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_matrix(ax, ay, az);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_elements.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // check each element as it leaves the block
    always @(posedge clk)
    begin
        element_t e;
        if (rst_n && strobe)
        begin
            if (expected_elements.size() == 0)
                report_mismatch("element with no request outstanding");
            else
            begin
                e = expected_elements.pop_front();
                if (row_index !== e.row || col_index !== e.col ||
                    element_value !== e.value || last_element !== e.last)
                    report_mismatch($sformatf(
                        "got (%0d,%0d)=%0d last %b, want (%0d,%0d)=%0d last %b",
                        row_index, col_index, element_value, last_element,
                        e.row, e.col, e.value, e.last));
            end
        end
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [15:0] edge_vals[10] = '{16'sh8000, 16'sh7FFF, 16'sd0,
            16'sd12868, -16'sd12868, 16'sd12870, -16'sd12870, 16'sd25736,
            16'sd1, -16'sd1};
        idle_pct = 0;
        send_request(16'sd0, 16'sd0, 16'sd0);
        foreach (edge_vals[i])
            send_request(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
        // eighth turns together stress the saturation
        send_request(16'sd6434, 16'sd6434, 16'sd6434);
        send_request(-16'sd6434, 16'sd12868, -16'sd6434);
        send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_request(16'sd12867, 16'sd12869, -16'sd12869);
        send_request(16'sh5555, 16'shAAAA, 16'sh5555);
        wait_drained();
    endtask

    task automatic random_phase(input int pct, input int count);
        idle_pct = pct;
        repeat (count)
            send_request(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random();
        random_phase(0, 120);
        random_phase(83, 100);
        // hold off until the pipeline has emptied
        wait_drained();
        random_phase(27, 100);
        random_phase(0, 80);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/erm_pkg.sv
rtl/erm_cell.sv
rtl/erm_matrix.sv
rtl/euler_rotation_matrix.sv
tb/sv/tb_euler_rotation_matrix.sv
